>>> hdl/siq_pkg.sv
// Shared types and codes for the sorted insert queue.
package siq_pkg;

  // Fixed field widths of the item format.
  localparam int unsigned KEY_W     = 32;
  localparam int unsigned PAY_IN_W  = 32;
  localparam int unsigned COUNT_W   = 5;
  localparam int unsigned IN_DATA_W = 64;
  localparam int unsigned OUT_DATA_W = 72;

  // Command carried with each input item.
  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  // Status returned with each result item.
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Control broadcast from the top level to every cell.
  typedef struct packed {
    logic              do_ins;
    logic              do_rem;
    logic              by_key;
    logic signed [KEY_W-1:0] key;
  } siq_ctl_t;

endpackage

>>> hdl/sorted_insert_queue.sv
// Top level of the sorted insert queue: cell chain, entry count and result register.
//
// Usage: each input item carries a command in in_tuser and a key and payload
// in in_tdata. Append puts the entry at the rear, insert puts it before the
// first stored entry with a strictly larger key, remove drops the front entry.
// Every accepted item returns exactly one result item holding the front entry
// after the operation, the entry count and a status (full or empty flags).
// Latency: the result item is presented in the cycle after acceptance.
// Throughput: one item per cycle. The figure is set by the insert-position
// search, which ripples combinationally through the chain of DEPTH cells.
// The result register frees as it is taken, so a new item is accepted while a
// finished result is being taken; while out_tready is low and a result is
// held, in_tready stays low and the queue contents do not change.
// Reset: rst_n low clears the entry count and any held result; the slot
// contents are not cleared and are never read before being written.
module sorted_insert_queue #(
  parameter int unsigned DEPTH        = 16,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // in_tdata: key [31:0], payload [63:32]
  input  logic [63:0] in_tdata,
  // in_tuser: cmd [1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_tdata: head_valid [0], head_key [32:1], head_payload [64:33],
  // entry_count [69:65], status [71:70]
  output logic [71:0] out_tdata
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = PAYLOAD_BITS;
  localparam int unsigned KW = siq_pkg::KEY_W;

  logic [CW-1:0]       count_r, count_nxt;
  logic                out_valid_r;
  logic                out_head_valid_r;
  logic [KW-1:0]       out_key_r;
  logic [31:0]         out_pay_r;
  logic [siq_pkg::COUNT_W-1:0] out_cnt_r;
  siq_pkg::status_t    out_status_r;

  logic                in_fire;
  siq_pkg::cmd_t       cmd;
  logic                is_ins, is_rem, full, empty;
  siq_pkg::siq_ctl_t   ctl;
  siq_pkg::status_t    status;
  logic [PW+31:0]      in_pay_ext;
  logic [PW-1:0]       new_pay;
  logic [PW+31:0]      head_pay_ext;
  logic [CW+4:0]       cnt_ext;
  logic                head_valid_nxt;

  logic signed [KW-1:0] cell_key     [DEPTH];
  logic [PW-1:0]        cell_pay     [DEPTH];
  logic signed [KW-1:0] cell_key_nxt [DEPTH];
  logic [PW-1:0]        cell_pay_nxt [DEPTH];
  logic [DEPTH:0]       found;

  // Handshake: take an item when the result register is free or being emptied.
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  // Command decode.
  assign cmd   = siq_pkg::cmd_t'(in_tuser);
  assign full  = count_r == CW'(DEPTH);
  assign empty = count_r == '0;

  always_comb begin
    is_ins = 1'b0;
    is_rem = 1'b0;
    unique case (cmd)
      siq_pkg::CMD_APPEND: is_ins = 1'b1;
      siq_pkg::CMD_INSERT: is_ins = 1'b1;
      siq_pkg::CMD_REMOVE: is_rem = 1'b1;
      siq_pkg::CMD_NOP:    is_ins = 1'b0;
      default:             is_ins = 1'b0;
    endcase
  end

  assign ctl.do_ins = in_fire && is_ins && !full;
  assign ctl.do_rem = in_fire && is_rem && !empty;
  assign ctl.by_key = cmd == siq_pkg::CMD_INSERT;
  assign ctl.key    = in_tdata[KW-1:0];

  always_comb begin
    if (is_ins && full) begin
      status = siq_pkg::ST_FULL;
    end else if (is_rem && empty) begin
      status = siq_pkg::ST_EMPTY;
    end else begin
      status = siq_pkg::ST_DONE;
    end
  end

  // Incoming payload kept to the stored width.
  assign in_pay_ext = {{PW{1'b0}}, in_tdata[63:32]};
  assign new_pay    = in_pay_ext[PW-1:0];

  // Chain of cells; the found flag ripples from the front toward the rear.
  assign found[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam int unsigned LI = (i == 0) ? 0 : i - 1;
    localparam int unsigned RI = (i == DEPTH - 1) ? i : i + 1;

    siq_cell #(
      .IDX (i),
      .CW  (CW),
      .PW  (PW)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .new_pay   (new_pay),
      .count     (count_r),
      .left_key  (cell_key[LI]),
      .left_pay  (cell_pay[LI]),
      .right_key (cell_key[RI]),
      .right_pay (cell_pay[RI]),
      .found_in  (found[i]),
      .found_out (found[i+1]),
      .key_o     (cell_key[i]),
      .pay_o     (cell_pay[i]),
      .key_nxt_o (cell_key_nxt[i]),
      .pay_nxt_o (cell_pay_nxt[i])
    );
  end

  // Entry count.
  always_comb begin
    count_nxt = count_r;
    if (ctl.do_ins) begin
      count_nxt = count_r + CW'(1);
    end else if (ctl.do_rem) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Result fields come from the front cell's next contents.
  assign head_valid_nxt = count_nxt != '0;
  assign head_pay_ext   = {32'd0, cell_pay_nxt[0]};
  assign cnt_ext        = {5'd0, count_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_head_valid_r <= head_valid_nxt;
      out_key_r        <= head_valid_nxt ? cell_key_nxt[0] : '0;
      out_pay_r        <= head_valid_nxt ? head_pay_ext[31:0] : 32'd0;
      out_cnt_r        <= cnt_ext[siq_pkg::COUNT_W-1:0];
      out_status_r     <= status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_status_r, out_cnt_r, out_pay_r, out_key_r, out_head_valid_r};

`ifndef SYNTHESIS
  // The count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above capacity");

  // An insert into a full queue leaves the count unchanged.
  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && is_ins && full) |=> (count_r == $past(count_r)))
    else $error("dropped insert changed the count");

  // An accepted item always yields a held result in the next cycle.
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted item produced no result");

  // A held result's head flag agrees with the live count.
  a_head_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_head_valid_r == (count_r != '0)))
    else $error("head flag disagrees with the count");

  // Insert and remove never act in the same cycle.
  a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.do_ins && ctl.do_rem))
    else $error("insert and remove at once");
`endif

endmodule

>>> hdl/siq_cell.sv
// One storage cell of the queue chain: holds one entry and shifts with its neighbors.
module siq_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 5,
  parameter int unsigned PW  = 32
) (
  input  logic                              clk,
  input  siq_pkg::siq_ctl_t                 ctl,
  input  logic [PW-1:0]                     new_pay,
  input  logic [CW-1:0]                     count,
  input  logic signed [siq_pkg::KEY_W-1:0]  left_key,
  input  logic [PW-1:0]                     left_pay,
  input  logic signed [siq_pkg::KEY_W-1:0]  right_key,
  input  logic [PW-1:0]                     right_pay,
  input  logic                              found_in,
  output logic                              found_out,
  output logic signed [siq_pkg::KEY_W-1:0]  key_o,
  output logic [PW-1:0]                     pay_o,
  output logic signed [siq_pkg::KEY_W-1:0]  key_nxt_o,
  output logic [PW-1:0]                     pay_nxt_o
);

  logic signed [siq_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [PW-1:0]                    pay_r, pay_nxt;
  logic                             occ;
  logic                             cond;

  // This cell holds a live entry when its place lies below the count.
  assign occ  = count > CW'(IDX);

  // The new entry belongs here if the slot is free or, for an insert by key, its key is larger.
  assign cond = !occ || (ctl.by_key && ($signed(ctl.key) < $signed(key_r)));
  assign found_out = found_in || cond;

  // Past the insert point entries move back by one; a removal moves them forward.
  always_comb begin
    key_nxt = key_r;
    pay_nxt = pay_r;
    if (ctl.do_ins) begin
      if (found_in) begin
        key_nxt = left_key;
        pay_nxt = left_pay;
      end else if (cond) begin
        key_nxt = ctl.key;
        pay_nxt = new_pay;
      end
    end else if (ctl.do_rem) begin
      key_nxt = right_key;
      pay_nxt = right_pay;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    pay_r <= pay_nxt;
  end

  assign key_o     = key_r;
  assign pay_o     = pay_r;
  assign key_nxt_o = key_nxt;
  assign pay_nxt_o = pay_nxt;

endmodule
